@@ rtl/core/tsef_pkg.sv @@
// Shared types, constants and arithmetic helpers for the thresholded Sobel edge filter.
package tsef_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 1024;
	localparam int unsigned MAX_HEIGHT_DEF = 4096;
	localparam int unsigned QUEUE_DEPTH    = 4;

	localparam logic [1:0] REG_THRESH = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [7:0]  THRESH_RST = 8'd150;
	localparam logic [10:0] WIDTH_RST  = 11'd256;
	localparam logic [12:0] HEIGHT_RST = 13'd256;

	// kernel term magnitudes: 255*1/8 and 255*2/8, truncated
	localparam logic signed [7:0] TERM_W1 = 8'sd31;
	localparam logic signed [7:0] TERM_W2 = 8'sd63;

	localparam int unsigned SQRT_STEPS = 8;

	typedef struct packed {
		logic [7:0]  thresh;
		logic [10:0] width;
		logic [12:0] height;
	} tsef_cfg_t;

	typedef struct packed {
		logic [9:0]  col;
		logic [11:0] row;
		logic        fend;
	} tsef_pos_t;

	// window bits: [2:0] left column, [5:3] centre, [8:6] right; bit 0 of each is the top row
	typedef struct packed {
		logic [8:0] win;
		tsef_pos_t  pos;
	} tsef_word_t;

	function automatic logic signed [7:0] grad_x(input logic [8:0] win);
		logic signed [7:0] g;
		g = 8'sd0;
		if (win[2]) g = g + TERM_W1;
		if (win[0]) g = g - TERM_W1;
		if (win[5]) g = g + TERM_W2;
		if (win[3]) g = g - TERM_W2;
		if (win[8]) g = g + TERM_W1;
		if (win[6]) g = g - TERM_W1;
		return g;
	endfunction

	function automatic logic signed [7:0] grad_y(input logic [8:0] win);
		logic signed [7:0] g;
		g = 8'sd0;
		if (win[0]) g = g + TERM_W1;
		if (win[6]) g = g - TERM_W1;
		if (win[1]) g = g + TERM_W2;
		if (win[7]) g = g - TERM_W2;
		if (win[2]) g = g + TERM_W1;
		if (win[8]) g = g - TERM_W1;
		return g;
	endfunction

	// gx^2 + gy^2, at most 2*125^2
	function automatic logic [14:0] mag_sq(input logic [8:0] win);
		logic signed [7:0]  gx;
		logic signed [7:0]  gy;
		logic signed [15:0] px;
		logic signed [15:0] py;
		gx = grad_x(win);
		gy = grad_y(win);
		px = gx * gx;
		py = gy * gy;
		return 15'(px[14:0] + py[14:0]);
	endfunction

	// one digit of floor(sqrt(s))
	function automatic logic [7:0] sqrt_bit(input logic [14:0] s, input logic [7:0] root,
		input logic [7:0] mask);
		logic [7:0]  trial;
		logic [15:0] sq;
		trial = root | mask;
		sq = 16'(trial) * 16'(trial);
		return ({1'b0, s} >= sq) ? trial : root;
	endfunction

endpackage

@@ rtl/core/tsef_front.sv @@
// Front end: position tracking, binarization, line store and window, border classification.
module tsef_front import tsef_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  tsef_cfg_t  cfg,
	input  logic [7:0] pixel,
	input  logic       frame_start,
	input  logic       push,
	output logic       full,
	input  logic       q_full,
	output logic       q_push,
	output tsef_word_t q_word
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned EW = (WW > 11) ? WW : 11;
	localparam int unsigned RW = $clog2(MAX_HEIGHT);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned EH = (HW > 13) ? HW : 13;

	logic [EW-1:0] w_ext;
	logic [EH-1:0] h_ext;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] cur_c;
	logic [RW-1:0] cur_r;
	logic [WW-1:0] c_ext;
	logic [HW-1:0] r_ext;
	logic [WW-1:0] c_inc;
	logic [HW-1:0] r_inc;

	logic          acc;
	logic          emit;
	logic          border;
	logic          fend;
	logic          bin;

	logic          v_s1;
	logic [CW-1:0] idx_s1;
	logic          bin_s1;
	logic          emit_s1;
	logic          border_s1;
	tsef_pos_t     pos_s1;
	logic          s1_move;

	logic [1:0]    lmem_q [MAX_WIDTH];
	logic [1:0]    rd_q;
	logic          fwd_q;
	logic [1:0]    fwd_d_q;
	logic [1:0]    rd_eff;
	logic [1:0]    wr_d;
	logic [5:0]    win_q;
	logic [8:0]    win9;

	logic          clr_q;
	logic [CW-1:0] clr_cnt_q;
	logic          mem_we;
	logic [CW-1:0] mem_wa;
	logic [1:0]    mem_wd;

	always_comb begin
		w_ext = EW'(cfg.width);
		if (w_ext < EW'(3)) begin
			w_ext = EW'(3);
		end else if (w_ext > EW'(MAX_WIDTH)) begin
			w_ext = EW'(MAX_WIDTH);
		end
		h_ext = EH'(cfg.height);
		if (h_ext < EH'(3)) begin
			h_ext = EH'(3);
		end else if (h_ext > EH'(MAX_HEIGHT)) begin
			h_ext = EH'(MAX_HEIGHT);
		end
	end

	assign w_eff = w_ext[WW-1:0];
	assign h_eff = h_ext[HW-1:0];

	assign cur_c = frame_start ? '0 : col_q;
	assign cur_r = frame_start ? '0 : row_q;
	assign c_ext = WW'(cur_c);
	assign r_ext = HW'(cur_r);
	assign c_inc = c_ext + WW'(1);
	assign r_inc = r_ext + HW'(1);

	assign bin    = pixel > cfg.thresh;
	assign emit   = (cur_c != '0) && (cur_r != '0) && (c_ext < w_eff) && (r_ext < h_eff);
	assign border = (cur_c == CW'(1)) || (cur_r == RW'(1));
	assign fend   = (c_ext == w_eff - WW'(1)) && (r_ext == h_eff - HW'(1));

	assign s1_move = v_s1 && (!emit_s1 || !q_full);
	assign full    = clr_q || (v_s1 && !s1_move);
	assign acc     = push && !full;

	// stored pair is {middle, upper}
	assign rd_eff = fwd_q ? fwd_d_q : rd_q;
	assign wr_d   = {bin_s1, rd_eff[1]};
	assign win9   = {bin_s1, rd_eff[1], rd_eff[0], win_q};

	assign q_push     = s1_move && emit_s1;
	assign q_word.win = border_s1 ? '0 : win9;
	assign q_word.pos = pos_s1;

	assign mem_we = clr_q || s1_move;
	assign mem_wa = clr_q ? clr_cnt_q : idx_s1;
	assign mem_wd = clr_q ? 2'b00 : wr_d;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			lmem_q[mem_wa] <= mem_wd;
		end
		if (acc) begin
			rd_q      <= lmem_q[cur_c];
			fwd_d_q   <= wr_d;
			idx_s1    <= cur_c;
			bin_s1    <= bin;
			emit_s1   <= emit;
			border_s1 <= border;
			pos_s1    <= '{col: 10'(cur_c - CW'(1)), row: 12'(cur_r - RW'(1)), fend: fend};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
			v_s1      <= 1'b0;
			fwd_q     <= 1'b0;
			win_q     <= '0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + CW'(1);
				if (clr_cnt_q == CW'(MAX_WIDTH - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (s1_move) begin
				win_q <= win9[8:3];
			end
			if (acc) begin
				v_s1  <= 1'b1;
				fwd_q <= s1_move && (cur_c == idx_s1);
				if (c_inc >= w_eff) begin
					col_q <= '0;
					row_q <= (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
				end else begin
					col_q <= c_inc[CW-1:0];
					row_q <= cur_r;
				end
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/tsef_queue.sv @@
// Short word queue between the front end and the magnitude pipeline.
module tsef_queue import tsef_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tsef_word_t wdata,
	output logic       full,
	input  logic       pop,
	output tsef_word_t rdata,
	output logic       empty
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);

	tsef_word_t    mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == (AW + 1)'(QUEUE_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (AW + 1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (AW + 1)'(1);
			end
		end
	end

endmodule

@@ rtl/core/tsef_back.sv @@
// Back end: gradient energy and a one-digit-per-stage square root pipeline.
module tsef_back import tsef_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  tsef_word_t  q_word,
	output logic        q_pop,
	output logic [7:0]  edge_res,
	output logic [9:0]  out_col,
	output logic [11:0] out_row,
	output logic        frame_end,
	output logic        empty,
	input  logic        pop
);

	logic        v_s    [0:SQRT_STEPS];
	logic [14:0] sum_s  [0:SQRT_STEPS-1];
	logic [7:0]  root_s [1:SQRT_STEPS];
	tsef_pos_t   pos_s  [0:SQRT_STEPS];
	logic        adv;

	assign adv       = !v_s[SQRT_STEPS] || pop;
	assign q_pop     = adv && !q_empty;
	assign empty     = !v_s[SQRT_STEPS];
	assign edge_res  = root_s[SQRT_STEPS];
	assign out_col   = pos_s[SQRT_STEPS].col;
	assign out_row   = pos_s[SQRT_STEPS].row;
	assign frame_end = pos_s[SQRT_STEPS].fend;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s[0] <= mag_sq(q_word.win);
			pos_s[0] <= q_word.pos;
			root_s[1] <= sqrt_bit(sum_s[0], 8'd0, 8'h80);
			for (int k = 1; k < SQRT_STEPS; k++) begin
				sum_s[k] <= sum_s[k-1];
			end
			for (int k = 2; k <= SQRT_STEPS; k++) begin
				root_s[k] <= sqrt_bit(sum_s[k-1], root_s[k-1], 8'(8'h80 >> (k - 1)));
			end
			for (int k = 1; k <= SQRT_STEPS; k++) begin
				pos_s[k] <= pos_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SQRT_STEPS; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s[0] <= !q_empty;
			for (int k = 1; k <= SQRT_STEPS; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

endmodule

@@ rtl/core/threshold_sobel_edge_filter_core.sv @@
// Top level of the thresholded Sobel edge filter: register port, front end, queue, back end.
// Takes one pixel per clock in raster order and sustains one pixel per clock while full is
// low; the line store is a single-port-write memory read once per pixel with a write-to-read
// bypass, so the front end never stalls on it. A result passes one front stage, the queue,
// the energy stage and eight square-root stages. Each pixel at column c, row r with
// c, r >= 1 produces the word for centre (c-1, r-1); the last row and column are not
// produced. After reset the line store is cleared one entry at a time, during which full is
// high; register writes are taken throughout. A held result freezes the back pipeline and a
// four-word queue absorbs the front end's output before full rises.
module threshold_sobel_edge_filter_core import tsef_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic [7:0]  pixel,
	input  logic        frame_start,
	input  logic        push,
	output logic        full,
	output logic [7:0]  edge_res,
	output logic [9:0]  out_col,
	output logic [11:0] out_row,
	output logic        frame_end,
	output logic        empty,
	input  logic        pop
);

	tsef_cfg_t  cfg_q;
	logic       cfg_wr;
	logic [1:0] reg_idx;
	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;
	tsef_word_t q_wdata;
	tsef_word_t q_rdata;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_THRESH: prdata = 32'(cfg_q.thresh);
			REG_WIDTH:  prdata = 32'(cfg_q.width);
			REG_HEIGHT: prdata = 32'(cfg_q.height);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{thresh: THRESH_RST, width: WIDTH_RST, height: HEIGHT_RST};
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_THRESH: cfg_q.thresh <= pwdata[7:0];
				REG_WIDTH:  cfg_q.width  <= pwdata[10:0];
				REG_HEIGHT: cfg_q.height <= pwdata[12:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	tsef_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pixel       (pixel),
		.frame_start (frame_start),
		.push        (push),
		.full        (full),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_word      (q_wdata)
	);

	tsef_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	tsef_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_word    (q_rdata),
		.q_pop     (q_pop),
		.edge_res  (edge_res),
		.out_col   (out_col),
		.out_row   (out_row),
		.frame_end (frame_end),
		.empty     (empty),
		.pop       (pop)
	);

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("front end pushed into a full queue");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("back end popped an empty queue");

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(edge_res) && $stable(out_col)
			&& $stable(out_row) && $stable(frame_end)))
		else $error("held result word changed");

endmodule

@@ tb/threshold_sobel_edge_filter_core_tb.sv @@
// Self-checking testbench for the thresholded Sobel edge filter core.
`timescale 1ns / 1ps

module threshold_sobel_edge_filter_core_tb;
	import tsef_pkg::*;

	typedef struct {
		logic [7:0]  mag;
		logic [9:0]  col;
		logic [11:0] row;
		logic        fend;
	} sobel_word_t;

	class edge_tracker;
		logic [7:0]  thr;
		logic [10:0] wid;
		logic [12:0] hgt;
		bit          upper [MAX_WIDTH_DEF];
		bit          middle [MAX_WIDTH_DEF];
		bit   [5:0]  win;
		int          pos_col;
		int          pos_row;
		sobel_word_t due_words[$];
		int          errors;

		function new();
			thr = THRESH_RST;
			wid = WIDTH_RST;
			hgt = HEIGHT_RST;
			foreach (upper[i]) begin
				upper[i] = 0;
				middle[i] = 0;
			end
			win = '0;
			pos_col = 0;
			pos_row = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_THRESH: thr = val[7:0];
				REG_WIDTH: wid = val[10:0];
				REG_HEIGHT: hgt = val[12:0];
				default: ;
			endcase
		endfunction

		function int eff_width();
			if (wid < 3) return 3;
			if (wid > MAX_WIDTH_DEF) return int'(MAX_WIDTH_DEF);
			return int'(wid);
		endfunction

		function int eff_height();
			if (hgt < 3) return 3;
			if (hgt > MAX_HEIGHT_DEF) return int'(MAX_HEIGHT_DEF);
			return int'(hgt);
		endfunction

		function int pending();
			return due_words.size();
		endfunction

		// advance the window by one accepted pixel and queue the word it releases
		function void take_pixel(logic [7:0] pix, logic fs);
			int          w, h, c, r, idx, x, y, gx, gy, s, m;
			bit          b;
			bit   [2:0]  cl, cc, cr;
			sobel_word_t wd;
			w = eff_width();
			h = eff_height();
			if (fs) begin
				pos_col = 0;
				pos_row = 0;
			end
			c = pos_col;
			r = pos_row;
			idx = c % MAX_WIDTH_DEF;
			b = (pix > thr);
			cl = win[2:0];
			cc = win[5:3];
			cr = {b, middle[idx], upper[idx]};
			if (c >= 1 && r >= 1 && c < w && r < h) begin
				x = c - 1;
				y = r - 1;
				m = 0;
				if (x > 0 && y > 0 && x < w - 1 && y < h - 1) begin
					gx = int'(TERM_W1) * (int'(cl[2]) - int'(cl[0]))
						+ int'(TERM_W2) * (int'(cc[2]) - int'(cc[0]))
						+ int'(TERM_W1) * (int'(cr[2]) - int'(cr[0]));
					gy = int'(TERM_W1) * (int'(cl[0]) - int'(cr[0]))
						+ int'(TERM_W2) * (int'(cl[1]) - int'(cr[1]))
						+ int'(TERM_W1) * (int'(cl[2]) - int'(cr[2]));
					s = gx * gx + gy * gy;
					while ((m + 1) * (m + 1) <= s)
						m++;
					if (m > 255)
						m = 255;
				end
				wd.mag = m[7:0];
				wd.col = x[9:0];
				wd.row = y[11:0];
				wd.fend = (x == w - 2 && y == h - 2);
				due_words.push_back(wd);
			end
			win = {cr, cc};
			upper[idx] = middle[idx];
			middle[idx] = b;
			if (c + 1 >= w) begin
				pos_col = 0;
				pos_row = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				pos_col = c + 1;
			end
		endfunction

		task report(string what, int got, int want);
			errors++;
			$display("mismatch %s: got %0d want %0d", what, got, want);
		endtask

		task check_word(logic [7:0] mag, logic [9:0] col, logic [11:0] row, logic fend);
			sobel_word_t wd;
			if (due_words.size() == 0) begin
				report("word with none due, col", int'(col), -1);
				return;
			end
			wd = due_words.pop_front();
			if (mag !== wd.mag)
				report($sformatf("edge_res at %0d,%0d", wd.col, wd.row), mag, wd.mag);
			if (col !== wd.col)
				report($sformatf("out_col at %0d,%0d", wd.col, wd.row), col, wd.col);
			if (row !== wd.row)
				report($sformatf("out_row at %0d,%0d", wd.col, wd.row), row, wd.row);
			if (fend !== wd.fend)
				report($sformatf("frame_end at %0d,%0d", wd.col, wd.row), fend, wd.fend);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic [7:0]  pixel;
	logic        frame_start;
	logic        push;
	logic        full;
	logic [7:0]  edge_res;
	logic [9:0]  out_col;
	logic [11:0] out_row;
	logic        frame_end;
	logic        empty;
	logic        pop;

	edge_tracker sb = new();
	int          max_gap = 4;
	int          hold_off = 0;

	threshold_sobel_edge_filter_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.pixel      (pixel),
		.frame_start(frame_start),
		.push       (push),
		.full       (full),
		.edge_res   (edge_res),
		.out_col    (out_col),
		.out_row    (out_row),
		.frame_end  (frame_end),
		.empty      (empty),
		.pop        (pop)
	);

	always #5 clk = ~clk;

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {idx, 2'b00};
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic reg_read_check(input logic [1:0] idx, input logic [31:0] want);
		logic [31:0] rd;
		logic [31:0] mask;
		mask = (idx == REG_THRESH) ? 32'hFF : (idx == REG_WIDTH) ? 32'h7FF : 32'h1FFF;
		apb_access(1'b0, idx, 32'd0, rd);
		if ((rd & mask) !== (want & mask))
			sb.report($sformatf("register %0d readback", idx), int'(rd & mask), int'(want & mask));
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] rd;
		apb_access(1'b1, idx, val, rd);
		sb.set_reg(idx, val);
		reg_read_check(idx, val);
	endtask

	task automatic send_pixel(input logic [7:0] p, input logic fs);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			@(negedge clk);
			push = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push = 1'b1;
		pixel = p;
		frame_start = fs;
		do @(posedge clk); while (full);
		sb.take_pixel(p, fs);
	endtask

	// stop offering pixels and wait for every due word plus the pipeline tail
	task automatic settle();
		@(negedge clk);
		push = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_run(input int n, input logic fs_first);
		for (int k = 0; k < n; k++)
			send_pixel(pick_pixel(), fs_first && k == 0);
	endtask

	// mostly whole frames with a leading frame_start; some cut short or with stray marks
	task automatic random_frames(input int n_items);
		int sent;
		int flen;
		sent = 0;
		while (sent < n_items) begin
			flen = sb.eff_width() * sb.eff_height();
			if ($urandom_range(0, 4) == 0)
				flen = $urandom_range(1, flen);
			for (int k = 0; k < flen && sent < n_items; k++) begin
				send_pixel(pick_pixel(),
					(k == 0 && $urandom_range(0, 9) != 0) || $urandom_range(0, 49) == 0);
				sent++;
			end
		end
	endtask

	task automatic set_frame(input logic [7:0] thr, input logic [10:0] w, input logic [12:0] h);
		settle();
		reg_write(REG_THRESH, thr);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
	endtask

	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			if (hold_off > 0) begin
				@(negedge clk);
				pop = 1'b0;
				repeat (hold_off - 1) @(negedge clk);
				hold_off = 0;
			end
			gap = $urandom_range(0, max_gap);
			if (gap > 0) begin
				@(negedge clk);
				pop = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			pop = 1'b1;
			do @(posedge clk); while (empty);
			sb.check_word(edge_res, out_col, out_row, frame_end);
		end
	end

	initial begin : stim
		logic [7:0] dir_pix [22];
		dir_pix = '{8'd255, 8'd0, 8'd101, 8'd100, 8'd0, 8'd255, 8'd255, 8'd0,
			8'd101, 8'd255, 8'd0, 8'd100, 8'd255, 8'd255, 8'd0, 8'd0,
			8'd200, 8'd1, 8'd255, 8'd99, 8'd255, 8'd0};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pixel = '0;
		frame_start = 1'b0;
		push = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		reg_read_check(REG_THRESH, 32'(THRESH_RST));
		reg_read_check(REG_WIDTH, 32'(WIDTH_RST));
		reg_read_check(REG_HEIGHT, 32'(HEIGHT_RST));

		// 4x4 frame around the threshold, implicit wrap, then frame_start at a row start
		set_frame(8'd100, 11'd4, 13'd4);
		for (int k = 0; k < 22; k++)
			send_pixel(dir_pix[k], k == 0 || k == 20);

		set_frame(8'd0, 11'd3, 13'd3);
		random_frames(60);
		set_frame(8'd255, 11'd5, 13'd4);
		random_frames(60);
		// sizes below range clamp to 3
		set_frame(8'd127, 11'd0, 13'd1);
		random_frames(40);

		max_gap = 0;
		set_frame(8'($urandom_range(0, 255)), 11'd6, 13'd5);
		random_frames(80);
		max_gap = 4;

		// receiver stalls long enough to fill the block
		set_frame(8'd128, 11'd7, 13'd6);
		hold_off = 200;
		random_frames(150);

		// width shrinks below the current column mid-frame
		set_frame(8'd100, 11'd8, 13'd6);
		send_run(30, 1'b1);
		settle();
		reg_write(REG_WIDTH, 11'd4);
		send_run(20, 1'b0);

		// width, then height, clamped from the top of the register range
		set_frame(8'($urandom_range(0, 255)), 11'd2047, 13'd4096);
		random_frames(80);
		set_frame(8'($urandom_range(0, 255)), 11'd4, 13'd8191);
		random_frames(60);

		for (int p = 0; p < 4; p++) begin
			max_gap = ($urandom_range(0, 3) == 0) ? 0 : 4;
			set_frame(8'($urandom_range(0, 255)), 11'($urandom_range(3, 9)),
				13'($urandom_range(3, 7)));
			random_frames(60);
		end
		max_gap = 4;

		@(negedge clk);
		push = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.pending() != 0)
			sb.report("words never produced", 0, sb.pending());
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
